>>> hw/rtl/bcsc_pkg.sv
`timescale 1ns / 1ps
// Package for the byte-coded stack processor core.
// Types, opcodes and constants shared by controller, datapath and top level.
package bcsc_pkg;

  localparam int unsigned MemAddrBits = 16;
  localparam int unsigned StackDepth  = 32;
  localparam int unsigned WordW       = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_REG   = 2'd3
  } cmd_e;

  // Command word and result word carried by the channels.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] program_counter;
    logic        flag_greater;
    logic        flag_less;
    logic        flag_equal;
    logic        running;
    logic        illegal_opcode;
  } out_word_t;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_JMP  = 8'h01;
  localparam logic [7:0] OP_CMP  = 8'h02;
  localparam logic [7:0] OP_JNE  = 8'h03;
  localparam logic [7:0] OP_JE   = 8'h04;
  localparam logic [7:0] OP_JG   = 8'h05;
  localparam logic [7:0] OP_JGE  = 8'h06;
  localparam logic [7:0] OP_JL   = 8'h07;
  localparam logic [7:0] OP_JLE  = 8'h08;
  localparam logic [7:0] OP_MOV  = 8'h09;
  localparam logic [7:0] OP_INC  = 8'h0A;
  localparam logic [7:0] OP_DEC  = 8'h0B;
  localparam logic [7:0] OP_ADD  = 8'h0C;
  localparam logic [7:0] OP_SUB  = 8'h0D;
  localparam logic [7:0] OP_MUL  = 8'h0E;
  localparam logic [7:0] OP_HLT  = 8'h0F;
  localparam logic [7:0] OP_PUSH = 8'h10;
  localparam logic [7:0] OP_POP  = 8'h11;
  localparam logic [7:0] OP_CALL = 8'h12;
  localparam logic [7:0] OP_RET  = 8'h13;

  localparam logic [7:0] ModeImmA = 8'b10000000;
  localparam logic [7:0] ModeImmB = 8'b01000000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEMRD,
    ST_FOP,
    ST_FMODE,
    ST_FB2,
    ST_FB3,
    ST_FB4,
    ST_FB5,
    ST_DECODE,
    ST_RDW0,
    ST_RDW1,
    ST_RDW2,
    ST_WRHI,
    ST_WRLO,
    ST_DONE
  } state_e;

  // Memory-address source chosen by the controller.
  typedef enum logic [1:0] {
    MA_CMD,
    MA_PC,
    MA_OPA,
    MA_OPA1
  } maddr_e;

  typedef struct packed {
    logic        mem_re;
    logic        mem_we;
    maddr_e      maddr;
    logic [2:0]  pc_off;   // byte offset from pc for fetch
    logic [2:0]  fetch_slot; // which fetch byte slot receives the captured byte
    logic        cap_fetch;
    logic        cap_rd;   // capture memory byte for read command
    logic        cap_w0;
    logic        cap_w1;
    logic        wr_hi;    // write high byte of store word, else low
    logic        wr_cmd;   // write command byte
    logic        commit;   // apply instruction effects
  } ctrl_t;

  typedef struct packed {
    logic [7:0] op;
    logic       ia;
    logic       ib;
    logic       needs_mem_write;
    logic       needs_word_read;
  } stat_t;

endpackage

>>> hw/rtl/bcsc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface bcsc_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/bcsc_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// Depends on nothing.
module bcsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/bcsc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences fetch, operand reads and write-back.
// Depends on bcsc_pkg.
module bcsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic             running_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  bcsc_pkg::stat_t  stat_i,
  output bcsc_pkg::ctrl_t  ctrl_o,
  output logic             out_load_o
);
  bcsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    ctrl_o     = '0;
    ctrl_o.maddr = bcsc_pkg::MA_CMD;
    unique case (state_q)
      bcsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd_i)
            bcsc_pkg::CMD_WRITE: begin
              ctrl_o.mem_we = 1'b1;
              ctrl_o.wr_cmd = 1'b1;
              state_d = bcsc_pkg::ST_DONE;
            end
            bcsc_pkg::CMD_READ: begin
              ctrl_o.mem_re = 1'b1;
              state_d = bcsc_pkg::ST_MEMRD;
            end
            bcsc_pkg::CMD_EXEC: begin
              state_d = running_i ? bcsc_pkg::ST_FOP : bcsc_pkg::ST_DONE;
            end
            default: state_d = bcsc_pkg::ST_DONE;
          endcase
        end
      end
      bcsc_pkg::ST_MEMRD: begin
        ctrl_o.cap_rd = 1'b1;
        state_d = bcsc_pkg::ST_DONE;
      end
      bcsc_pkg::ST_FOP: begin
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd0;
        state_d = bcsc_pkg::ST_FMODE;
      end
      bcsc_pkg::ST_FMODE: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd0;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd1;
        state_d = bcsc_pkg::ST_FB2;
      end
      bcsc_pkg::ST_FB2: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd1;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd2;
        state_d = bcsc_pkg::ST_FB3;
      end
      bcsc_pkg::ST_FB3: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd2;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd3;
        state_d = bcsc_pkg::ST_FB4;
      end
      bcsc_pkg::ST_FB4: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd3;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd4;
        state_d = bcsc_pkg::ST_FB5;
      end
      bcsc_pkg::ST_FB5: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd4;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_PC;
        ctrl_o.pc_off = 3'd5;
        state_d = bcsc_pkg::ST_DECODE;
      end
      bcsc_pkg::ST_DECODE: begin
        ctrl_o.cap_fetch  = 1'b1;
        ctrl_o.fetch_slot = 3'd5;
        state_d = bcsc_pkg::ST_RDW0;
      end
      bcsc_pkg::ST_RDW0: begin
        if (stat_i.needs_word_read) begin
          ctrl_o.mem_re = 1'b1;
          ctrl_o.maddr  = bcsc_pkg::MA_OPA;
          state_d = bcsc_pkg::ST_RDW1;
        end else if (stat_i.needs_mem_write) begin
          state_d = bcsc_pkg::ST_WRHI;
        end else begin
          ctrl_o.commit = 1'b1;
          state_d = bcsc_pkg::ST_DONE;
        end
      end
      bcsc_pkg::ST_RDW1: begin
        ctrl_o.cap_w0 = 1'b1;
        ctrl_o.mem_re = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_OPA1;
        state_d = bcsc_pkg::ST_RDW2;
      end
      bcsc_pkg::ST_RDW2: begin
        ctrl_o.cap_w1 = 1'b1;
        state_d = bcsc_pkg::ST_WRHI;
      end
      bcsc_pkg::ST_WRHI: begin
        ctrl_o.mem_we = 1'b1;
        ctrl_o.wr_hi  = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_OPA;
        state_d = bcsc_pkg::ST_WRLO;
      end
      bcsc_pkg::ST_WRLO: begin
        ctrl_o.mem_we = 1'b1;
        ctrl_o.maddr  = bcsc_pkg::MA_OPA1;
        ctrl_o.commit = 1'b1;
        state_d = bcsc_pkg::ST_DONE;
      end
      bcsc_pkg::ST_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          out_load_o = 1'b1;
          state_d = bcsc_pkg::ST_IDLE;
        end
      end
      default: state_d = bcsc_pkg::ST_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/bcsc_dp.sv
`timescale 1ns / 1ps
// Datapath: memory, register file, stack, pc, flags and result register.
// Depends on bcsc_pkg and bcsc_ram.
module bcsc_dp #(
  parameter int unsigned MemAddrBits = bcsc_pkg::MemAddrBits,
  parameter int unsigned StackDepth  = bcsc_pkg::StackDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_take_i,
  input  logic [1:0]      cmd_i,
  input  logic [15:0]     addr_i,
  input  logic [7:0]      wbyte_i,
  input  bcsc_pkg::ctrl_t ctrl_i,
  input  logic            out_load_i,
  input  logic            out_ready_i,
  output bcsc_pkg::stat_t stat_o,
  output logic            running_o,
  output logic            out_valid_o,
  output logic [15:0]     read_value_o,
  output logic [15:0]     program_counter_o,
  output logic            flag_greater_o,
  output logic            flag_less_o,
  output logic            flag_equal_o,
  output logic            running_out_o,
  output logic            illegal_opcode_o
);
  localparam int unsigned SpW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam logic [SpW-1:0] SpTop = SpW'(StackDepth - 1);

  logic [1:0]  cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  fb_q [6];
  logic [15:0] regs_q [8];
  logic [15:0] stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  logic [15:0] pc_q;
  logic [2:0]  flags_q;
  logic        run_q, ill_q;
  logic [15:0] rv_q, memw_q;
  logic        ov_q;
  logic [15:0] out_rv_q, out_pc_q;
  logic [2:0]  out_fl_q;
  logic        out_run_q, out_ill_q;

  logic [7:0]  op, mode;
  logic        ia, ib;
  logic [2:0]  ra, rb;
  logic [15:0] opa, opb, target, wval;
  logic [SpW-1:0] sp_inc, sp_dec;
  logic [15:0] maddr16;
  logic [MemAddrBits-1:0] ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;

  assign op   = fb_q[0];
  assign mode = fb_q[1];
  assign ia   = (mode & bcsc_pkg::ModeImmA) != 8'd0;
  assign ib   = (mode & bcsc_pkg::ModeImmB) != 8'd0;
  assign ra   = mode[5:3];
  assign rb   = mode[2:0];
  assign opa  = ia ? {fb_q[2], fb_q[3]} : regs_q[ra];
  assign opb  = ib ? (ia ? {fb_q[4], fb_q[5]} : {fb_q[2], fb_q[3]}) : regs_q[rb];
  assign target = {fb_q[1], fb_q[2]};
  assign sp_inc = (sp_q == SpTop) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SpTop : sp_q - 1'b1;

  always_comb begin
    stat_o = '0;
    stat_o.op = op;
    stat_o.ia = ia;
    stat_o.ib = ib;
    stat_o.needs_word_read = ia && (op == bcsc_pkg::OP_INC || op == bcsc_pkg::OP_DEC);
    stat_o.needs_mem_write = ia && (op == bcsc_pkg::OP_MOV || op == bcsc_pkg::OP_POP);
  end

  // word to store for memory-destination instructions
  always_comb begin
    case (op)
      bcsc_pkg::OP_INC: wval = memw_q + 16'd1;
      bcsc_pkg::OP_DEC: wval = memw_q - 16'd1;
      bcsc_pkg::OP_POP: wval = stk_q[sp_inc];
      default:          wval = opb;
    endcase
  end

  always_comb begin
    case (ctrl_i.maddr)
      bcsc_pkg::MA_PC:   maddr16 = pc_q + 16'(ctrl_i.pc_off);
      bcsc_pkg::MA_OPA:  maddr16 = opa;
      bcsc_pkg::MA_OPA1: maddr16 = opa + 16'd1;
      default:           maddr16 = in_take_i ? addr_i : addr_q;
    endcase
  end
  assign ram_addr  = maddr16[MemAddrBits-1:0];
  assign ram_wdata = ctrl_i.wr_cmd ? wbyte_i : (ctrl_i.wr_hi ? wval[15:8] : wval[7:0]);

  bcsc_ram #(.Width(8), .Depth(2 ** MemAddrBits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.mem_we),
    .re_i   (ctrl_i.mem_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
    end
    if (ctrl_i.cap_fetch) fb_q[ctrl_i.fetch_slot] <= ram_rdata;
    if (ctrl_i.cap_w0) memw_q[15:8] <= ram_rdata;
    if (ctrl_i.cap_w1) memw_q[7:0] <= ram_rdata;
    if (ctrl_i.cap_rd) rv_q <= {8'd0, ram_rdata};
    else if (in_take_i) rv_q <= (cmd_i == bcsc_pkg::CMD_REG) ? regs_q[addr_i[2:0]] : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= '0;
      sp_q <= SpTop;
      pc_q <= '0;
      flags_q <= '0;
      run_q <= 1'b1;
      ill_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      case (op)
        bcsc_pkg::OP_NOP, bcsc_pkg::OP_ADD, bcsc_pkg::OP_SUB, bcsc_pkg::OP_MUL:
          pc_q <= pc_q + 16'd1;
        bcsc_pkg::OP_JMP: pc_q <= target;
        bcsc_pkg::OP_CMP: begin
          flags_q <= {opa == opb, opa < opb, opa > opb};
          pc_q <= pc_q + 16'd2 + (ia ? 16'd2 : 16'd0) + (ib ? 16'd2 : 16'd0);
        end
        bcsc_pkg::OP_JNE: pc_q <= !flags_q[2] ? target : pc_q + 16'd3;
        bcsc_pkg::OP_JE:  pc_q <= flags_q[2] ? target : pc_q + 16'd3;
        bcsc_pkg::OP_JG:  pc_q <= flags_q[0] ? target : pc_q + 16'd3;
        bcsc_pkg::OP_JGE: pc_q <= (flags_q[0] | flags_q[2]) ? target : pc_q + 16'd3;
        bcsc_pkg::OP_JL:  pc_q <= flags_q[1] ? target : pc_q + 16'd3;
        bcsc_pkg::OP_JLE: pc_q <= (flags_q[1] | flags_q[2]) ? target : pc_q + 16'd3;
        bcsc_pkg::OP_MOV: begin
          if (!ia) regs_q[ra] <= opb;
          pc_q <= pc_q + 16'd2 + (ia ? 16'd2 : 16'd0) + (ib ? 16'd2 : 16'd0);
        end
        bcsc_pkg::OP_INC, bcsc_pkg::OP_DEC: begin
          if (!ia) regs_q[ra] <= (op == bcsc_pkg::OP_INC) ? regs_q[ra] + 16'd1
                                                          : regs_q[ra] - 16'd1;
          pc_q <= pc_q + (ia ? 16'd4 : 16'd2);
        end
        bcsc_pkg::OP_HLT: begin
          run_q <= 1'b0;
          pc_q <= pc_q + 16'd1;
        end
        bcsc_pkg::OP_PUSH: begin
          stk_q[sp_q] <= opa;
          sp_q <= sp_dec;
          pc_q <= pc_q + (ia ? 16'd4 : 16'd2);
        end
        bcsc_pkg::OP_POP: begin
          if (!ia) regs_q[ra] <= stk_q[sp_inc];
          sp_q <= sp_inc;
          pc_q <= pc_q + (ia ? 16'd4 : 16'd2);
        end
        bcsc_pkg::OP_CALL: begin
          stk_q[sp_q] <= pc_q + 16'd3;
          sp_q <= sp_dec;
          pc_q <= target;
        end
        bcsc_pkg::OP_RET: begin
          sp_q <= sp_inc;
          pc_q <= stk_q[sp_inc];
        end
        default: begin
          run_q <= 1'b0;
          ill_q <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load_i) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      out_rv_q  <= (cmd_q == bcsc_pkg::CMD_WRITE) ? 16'd0 : rv_q;
      out_pc_q  <= pc_q;
      out_fl_q  <= flags_q;
      out_run_q <= run_q;
      out_ill_q <= ill_q;
    end
  end

  assign running_o         = run_q;
  assign out_valid_o       = ov_q;
  assign read_value_o      = out_rv_q;
  assign program_counter_o = out_pc_q;
  assign flag_greater_o    = out_fl_q[0];
  assign flag_less_o       = out_fl_q[1];
  assign flag_equal_o      = out_fl_q[2];
  assign running_out_o     = out_run_q;
  assign illegal_opcode_o  = out_ill_q;
endmodule

>>> hw/rtl/byte_coded_stack_cpu_core.sv
`timescale 1ns / 1ps
// Top level of the byte-coded stack processor core.
// Depends on bcsc_pkg, bcsc_if, bcsc_ctrl, bcsc_dp and bcsc_ram.
//
// Usage:
//   in_ch carries one command word {command, address, write_byte}; out_ch
//   returns one result word {read_value, program_counter, flags, running,
//   illegal_opcode} per command.
//   A write or register read goes straight to the result state; a memory
//   read first captures the byte. An execute fetches six bytes, decodes,
//   reads and writes back the word for INC/DEC on memory, writes it for
//   MOV/POP to memory, then commits; a halted execute skips all that. The
//   core takes one command at a time; the program/data memory has a single
//   byte port (six fetch reads plus up to two reads and two writes).
//   The result sits in an output register; if the receiver stalls, the
//   core waits with the next result until the held one is taken.
//   Reset clears registers, stack, pc and flags, sets the stack pointer to
//   the top and running to one. Memory content is undefined until written.
module byte_coded_stack_cpu_core #(
  parameter int unsigned MemAddrBits = bcsc_pkg::MemAddrBits,
  parameter int unsigned StackDepth  = bcsc_pkg::StackDepth
) (
  input logic clk_i,
  input logic rst_ni,
  bcsc_if.sink   in_ch,
  bcsc_if.source out_ch
);
  bcsc_pkg::ctrl_t ctrl;
  bcsc_pkg::stat_t stat;
  logic in_ready, out_load, running, in_take;

  assign in_ch.ready = in_ready;
  assign in_take = in_ch.valid && in_ready;

  bcsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .cmd_i      (in_ch.payload.command),
    .running_i  (running),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .out_load_o (out_load)
  );

  bcsc_dp #(.MemAddrBits(MemAddrBits), .StackDepth(StackDepth)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_take_i        (in_take),
    .cmd_i            (in_ch.payload.command),
    .addr_i           (in_ch.payload.address),
    .wbyte_i          (in_ch.payload.write_byte),
    .ctrl_i           (ctrl),
    .out_load_i       (out_load),
    .out_ready_i      (out_ch.ready),
    .stat_o           (stat),
    .running_o        (running),
    .out_valid_o      (out_ch.valid),
    .read_value_o     (out_ch.payload.read_value),
    .program_counter_o(out_ch.payload.program_counter),
    .flag_greater_o   (out_ch.payload.flag_greater),
    .flag_less_o      (out_ch.payload.flag_less),
    .flag_equal_o     (out_ch.payload.flag_equal),
    .running_out_o    (out_ch.payload.running),
    .illegal_opcode_o (out_ch.payload.illegal_opcode)
  );
endmodule

>>> verif/tb_byte_coded_stack_cpu_core.sv
`timescale 1ns / 1ps
// Testbench for byte_coded_stack_cpu_core: builds small programs in memory byte by byte,
// executes them and checks every result word against a behavioral model of the core.
// Depends on bcsc_pkg, bcsc_if and the core RTL.
module tb_byte_coded_stack_cpu_core;
  import bcsc_pkg::*;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] pc;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        running;
    logic        illegal;
  } core_result_t;

  class core_scoreboard;
    bit [7:0]     mem [65536];
    bit           known [65536];
    bit [15:0]    regs [8];
    bit [15:0]    stk [StackDepth];
    bit [4:0]     sp;
    bit [15:0]    pc;
    bit           gt, lt, eq, running, illegal;
    core_result_t pending_q [$];
    bit [15:0]    written_q [$];
    bit           failed;

    function void init();
      foreach (regs[i]) regs[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      sp = StackDepth - 1;
      pc = '0;
      {gt, lt, eq, illegal} = '0;
      running = 1'b1;
    endfunction

    function bit [15:0] word_at(bit [15:0] a);
      return {mem[a], mem[16'(a + 1)]};
    endfunction

    function void store_word(bit [15:0] a, bit [15:0] v);
      mem[a] = v[15:8];
      mem[16'(a + 1)] = v[7:0];
      known[a] = 1'b1;
      known[16'(a + 1)] = 1'b1;
    endfunction

    function void push_stack(bit [15:0] v);
      stk[sp] = v;
      sp = sp - 1'b1;
    endfunction

    function bit [15:0] pop_stack();
      sp = sp + 1'b1;
      return stk[sp];
    endfunction

    function void step_instr();
      bit [15:0] a, opa, opb, target, nxt, len1, len2, v;
      bit [7:0]  op, mode;
      bit        ia, ib, take;
      bit [2:0]  ra, rb;
      a      = pc;
      op     = mem[a];
      mode   = mem[16'(a + 1)];
      ia     = mode[7];
      ib     = mode[6];
      ra     = mode[5:3];
      rb     = mode[2:0];
      opa    = ia ? word_at(16'(a + 2)) : regs[ra];
      opb    = ib ? word_at(16'(a + 2 + (ia ? 2 : 0))) : regs[rb];
      len2   = 2 + (ia ? 2 : 0) + (ib ? 2 : 0);
      len1   = 2 + (ia ? 2 : 0);
      target = word_at(16'(a + 1));
      nxt    = a + 1;
      take   = 1'b0;
      case (op)
        OP_NOP, OP_ADD, OP_SUB, OP_MUL: ;
        OP_JMP: nxt = target;
        OP_CMP: begin
          gt = opa > opb;
          lt = opa < opb;
          eq = opa == opb;
          nxt = a + len2;
        end
        OP_JNE, OP_JE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
          case (op)
            OP_JNE:  take = !eq;
            OP_JE:   take = eq;
            OP_JG:   take = gt;
            OP_JGE:  take = gt || eq;
            OP_JL:   take = lt;
            default: take = lt || eq;
          endcase
          nxt = take ? target : 16'(a + 3);
        end
        OP_MOV: begin
          if (ia) store_word(opa, opb);
          else regs[ra] = opb;
          nxt = a + len2;
        end
        OP_INC, OP_DEC: begin
          v = (op == OP_INC) ? 16'd1 : 16'hFFFF;
          if (ia) store_word(opa, word_at(opa) + v);
          else regs[ra] = regs[ra] + v;
          nxt = a + len1;
        end
        OP_HLT: running = 1'b0;
        OP_PUSH: begin
          push_stack(opa);
          nxt = a + len1;
        end
        OP_POP: begin
          v = pop_stack();
          if (ia) store_word(opa, v);
          else regs[ra] = v;
          nxt = a + len1;
        end
        OP_CALL: begin
          push_stack(16'(a + 3));
          nxt = target;
        end
        OP_RET: nxt = pop_stack();
        default: begin
          running = 1'b0;
          illegal = 1'b1;
          nxt = a;
        end
      endcase
      pc = nxt;
    endfunction

    function void note(cmd_e c, bit [15:0] ad, bit [7:0] b);
      core_result_t r;
      r.read_value = '0;
      case (c)
        CMD_WRITE: begin
          mem[ad] = b;
          if (!known[ad]) written_q.push_back(ad);
          known[ad] = 1'b1;
        end
        CMD_READ: r.read_value = {8'h00, mem[ad]};
        CMD_EXEC: if (running) step_instr();
        default:  r.read_value = regs[ad[2:0]];
      endcase
      r.pc = pc;
      r.gt = gt;
      r.lt = lt;
      r.eq = eq;
      r.running = running;
      r.illegal = illegal;
      pending_q.push_back(r);
    endfunction

    function void field(string name, logic [15:0] e, logic [15:0] act);
      if (e !== act) begin
        $display("%0t: %s expected %h actual %h", $time, name, e, act);
        failed = 1'b1;
      end
    endfunction

    function void check(out_word_t w);
      core_result_t e, act;
      act = w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, w);
        failed = 1'b1;
        return;
      end
      e = pending_q.pop_front();
      field("read_value", e.read_value, act.read_value);
      field("program_counter", e.pc, act.pc);
      field("flag_greater", e.gt, act.gt);
      field("flag_less", e.lt, act.lt);
      field("flag_equal", e.eq, act.eq);
      field("running", e.running, act.running);
      field("illegal_opcode", e.illegal, act.illegal);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  core_scoreboard sb;
  int burst_left;
  int n_items;
  int ready_mode, ready_len, ready_cnt;

  bcsc_if #(.payload_t(in_word_t))  in_ch (clk_i);
  bcsc_if #(.payload_t(out_word_t)) out_ch (clk_i);

  byte_coded_stack_cpu_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver stall pattern: segments of always ready, coin flip, or one in three
  always @(posedge clk_i) begin
    if (ready_len == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_len  <= $urandom_range(4, 60);
    end else begin
      ready_len <= ready_len - 1;
    end
    ready_cnt <= ready_cnt + 1;
    case (ready_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (ready_cnt % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.payload);
  end

  task automatic send(cmd_e c, logic [15:0] ad, logic [7:0] b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {c, ad, b};
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(c, ad, b);
    burst_left--;
    n_items++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // write six bytes at pc, fill an INC/DEC memory operand if unknown, then execute
  task automatic run_instr(logic [7:0] op, logic [7:0] mode, logic [31:0] rest);
    logic [15:0] a, tgt;
    a = sb.pc;
    send(CMD_WRITE, a, op);
    send(CMD_WRITE, a + 16'd1, mode);
    for (int k = 0; k < 4; k++) send(CMD_WRITE, a + 16'(k + 2), rest[31 - 8*k -: 8]);
    tgt = rest[31:16];
    if ((op == OP_INC || op == OP_DEC) && mode[7]) begin
      if (!sb.known[tgt]) send(CMD_WRITE, tgt, 8'($urandom));
      if (!sb.known[16'(tgt + 1)]) send(CMD_WRITE, tgt + 16'd1, 8'($urandom));
    end
    send(CMD_EXEC, '0, '0);
  endtask

  function automatic bit code_ready();
    logic [15:0] a, tgt;
    logic [7:0]  op;
    a = sb.pc;
    for (int k = 0; k < 6; k++) if (!sb.known[16'(a + k)]) return 1'b0;
    op = sb.mem[a];
    if (op == OP_HLT || op > OP_RET) return 1'b0;
    tgt = sb.word_at(16'(a + 2));
    if ((op == OP_INC || op == OP_DEC) && sb.mem[16'(a + 1)][7])
      return sb.known[tgt] && sb.known[16'(tgt + 1)];
    return 1'b1;
  endfunction

  task automatic random_instr();
    logic [7:0]  op;
    logic [31:0] rest;
    op = 8'($urandom_range(0, 18));
    if (op >= OP_HLT) op = op + 8'd1;
    rest = $urandom;
    // keep most memory-operand addresses in the low 256 bytes
    if ($urandom_range(0, 3) != 0) rest[31:16] = {8'h00, rest[23:16]};
    run_instr(op, 8'($urandom), rest);
  endtask

  initial begin
    logic [15:0] ad;
    sb = new();
    sb.init();
    burst_left = 0;
    n_items = 0;
    ready_len = 0;
    ready_cnt = 0;
    ready_mode = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_WRITE, 16'hFFFF, 8'hFF);
    send(CMD_WRITE, 16'h0000, 8'h00);
    send(CMD_READ, 16'hFFFF, 8'h00);
    send(CMD_READ, 16'h0000, 8'hFF);
    send(CMD_REG, 16'hFFFF, 8'h00);
    run_instr(OP_MOV, 8'h78, 32'hFFFF_0000);
    send(CMD_REG, 16'h0007, 8'h00);
    run_instr(OP_JMP, 8'hFF, 32'hFD00_0000);
    run_instr(OP_CMP, 8'hC0, 32'h8000_7FFF);

    while (n_items < 700) begin
      if (n_items > 350 && n_items < 360) drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: random_instr();
        6: begin
          ad = 16'($urandom);
          if ($urandom_range(0, 1)) ad = sb.pc + 16'($urandom_range(0, 12));
          send(CMD_WRITE, ad, 8'($urandom));
        end
        7: send(CMD_READ, sb.written_q[$urandom_range(0, sb.written_q.size() - 1)],
                8'($urandom));
        8: send(CMD_REG, 16'($urandom), 8'($urandom));
        default: if (code_ready()) send(CMD_EXEC, 16'($urandom), 8'($urandom));
                 else random_instr();
      endcase
    end

    if ($urandom_range(0, 1)) run_instr(OP_HLT, 8'($urandom), $urandom);
    else run_instr(8'($urandom_range(OP_RET + 1, 255)), 8'($urandom), $urandom);
    send(CMD_EXEC, '0, '0);
    send(CMD_REG, 16'h0007, 8'h00);
    send(CMD_READ, 16'hFFFF, 8'h00);
    send(CMD_WRITE, 16'h0000, 8'hA5);
    send(CMD_EXEC, '0, '0);
    drain();
    repeat (20) @(posedge clk_i);
    if (!sb.failed && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bcsc_pkg.sv
hw/rtl/bcsc_if.sv
hw/rtl/bcsc_ram.sv
hw/rtl/bcsc_ctrl.sv
hw/rtl/bcsc_dp.sv
hw/rtl/byte_coded_stack_cpu_core.sv
verif/tb_byte_coded_stack_cpu_core.sv
